[rtl/bpdc_pkg.sv]
package bpdc_pkg;

   localparam int VAL_W     = 40;
   localparam int YLD_W     = 24;
   localparam int YR_W      = 25;
   localparam int YRS_W     = 7;
   localparam int PPY_W     = 4;
   localparam int NRAW_W    = 11;
   localparam int PV_W      = 41;
   localparam int D_W       = 31;
   localparam int G_W       = 26;
   localparam int PM_W      = 44;
   localparam int PMM_W     = 48;
   localparam int DEN2_W    = 69;
   localparam int DEN_W     = 74;
   localparam int MA_W      = 48;
   localparam int DFRAC     = 30;
   localparam int DUR_W     = 24;
   localparam int CONV_W    = 32;
   localparam int STAT_W    = 2;
   localparam int CSR_IDX_W = 3;

   localparam logic [YR_W-1:0] YONE = 25'h100_0000;

   localparam logic [CSR_IDX_W-1:0] CSR_FACE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUPON = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_YIELD  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_YEARS  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PPY    = 3'd4;

   localparam logic [STAT_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STAT_W-1:0] STATUS_SAT  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_PD,
      ST_PCF,
      ST_PK,
      ST_PKK,
      ST_PEND,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_M5
   } state_type;

   typedef enum logic [2:0] {
      DV_R,
      DV_C,
      DV_Q,
      DV_MAC,
      DV_MOD,
      DV_CONV
   } div_type;

endpackage

[rtl/bpdc_mul.sv]
module bpdc_mul
   import bpdc_pkg::*;
#(
   parameter int A_W = 48,
   parameter int B_W = 31
) (
   input  logic               clock,
   input  logic [A_W-1:0]     a,
   input  logic [B_W-1:0]     b,
   output logic [A_W+B_W-1:0] p
);

   localparam int LO_W = A_W / 2;
   localparam int HI_W = A_W - LO_W;

   // Two-stage pipeline: the low half of a is multiplied in the first stage and
   // the high half in the second, so each stage holds one narrow multiplier.
   logic [LO_W+B_W-1:0] lo_ff, lo_in;
   logic [HI_W-1:0]     ahi_ff, ahi_in;
   logic [B_W-1:0]      b_ff, b_in;
   logic [HI_W+B_W-1:0] hi_prod;
   logic [A_W+B_W-1:0]  p_ff, p_in;

   assign lo_in   = (LO_W+B_W)'(a[LO_W-1:0]) * (LO_W+B_W)'(b);
   assign ahi_in  = a[A_W-1:LO_W];
   assign b_in    = b;
   assign hi_prod = (HI_W+B_W)'(ahi_ff) * (HI_W+B_W)'(b_ff);
   assign p_in    = (A_W+B_W)'(lo_ff) + ((A_W+B_W)'(hi_prod) << LO_W);

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      ahi_ff <= ahi_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
   end

   assign p = p_ff;

endmodule

[rtl/bpdc_div.sv]
module bpdc_div
   import bpdc_pkg::*;
#(
   parameter int NUM_W = 117,
   parameter int D_BITS = 74
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [D_BITS-1:0] den,
   output logic              done,
   output logic [NUM_W-1:0]  quo
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [D_BITS-1:0] rem_ff, rem_in;
   logic [D_BITS-1:0] den_ff, den_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [D_BITS:0]   sh;
   logic [D_BITS:0]   diff;
   logic              ge;

   // Restoring division: one quotient bit per cycle, dividend shifted out MSB first.
   always_comb begin
      sh      = {rem_ff, quo_ff[NUM_W-1]};
      ge      = (sh >= {1'b0, den_ff});
      diff    = sh - {1'b0, den_ff};
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = num;
         rem_in = '0;
         den_in = den;
         cnt_in = CNT_W'(NUM_W);
      end else if (cnt_ff != '0) begin
         quo_in  = {quo_ff[NUM_W-2:0], ge};
         rem_in  = ge ? diff[D_BITS-1:0] : sh[D_BITS-1:0];
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

[rtl/bond_price_duration_convexity.sv]
// Bond price, Macaulay and modified duration, and convexity.
// Configuration: write face value, coupon, yield, years and payments per year
// through the csr_ port while busy is low; a write takes effect at its edge.
// Request: a market price is taken at an edge where start is high and busy is
// low. Busy then stays high until the result is presented.
// Result: one transfer per request, marked by rsp_strobe for exactly one cycle
// and held on the rsp_ ports until the next. The receiver has no way to stall it.
// Sequence: three divisions come before the period walk, which visits each of
// the coupon periods in turn, and three come after. The divider is 117 bits
// wide at the default MAX_PERIODS and retires one quotient bit per cycle.
// Every multiply step runs on the single shared two-stage multiplier; a period
// walks through ST_PD, ST_PCF, ST_PK and ST_PKK. A zero market price skips the
// final divisions. Only one request is in flight, so a new request is taken
// only once the result of the last one is presented.
// Reset clears the control state and restores the configuration defaults
// (all zero, one payment per year); no result is pending after reset.
module bond_price_duration_convexity
   import bpdc_pkg::*;
#(
   parameter int MAX_PERIODS = 2048
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  logic [VAL_W-1:0]     req_market_price,
   output logic                 rsp_strobe,
   output logic [VAL_W-1:0]     rsp_fair_price,
   output logic [DUR_W-1:0]     rsp_macaulay_duration,
   output logic [DUR_W-1:0]     rsp_modified_duration,
   output logic [CONV_W-1:0]    rsp_convexity,
   output logic [STAT_W-1:0]    rsp_status,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [VAL_W-1:0]     csr_write_data
);

   localparam int K_W   = $clog2(MAX_PERIODS + 1);
   localparam int KK_W  = 2 * K_W;
   localparam int MB_W  = (KK_W > D_W) ? KK_W : D_W;
   localparam int P_W   = MA_W + MB_W;
   localparam int TOT_W = PV_W + K_W;
   localparam int S1_W  = PV_W + 2 * K_W;
   localparam int S2_W  = PV_W + KK_W + K_W;
   localparam int NUM_W = S2_W + 40;

   // Configuration registers.
   logic [VAL_W-1:0] face_ff, face_in;
   logic [VAL_W-1:0] coupon_ff, coupon_in;
   logic [YLD_W-1:0] yield_ff, yield_in;
   logic [YRS_W-1:0] years_ff, years_in;
   logic [PPY_W-1:0] ppy_ff, ppy_in;

   state_type state_ff, state_in;
   div_type   dv_ff, dv_in;
   logic      ph_ff, ph_in;

   logic [VAL_W-1:0]  price_ff, price_in;
   logic [PPY_W-1:0]  m_ff, m_in;
   logic [K_W-1:0]    n_ff, n_in;
   logic [YLD_W-1:0]  r_ff, r_in;
   logic [VAL_W-1:0]  c_ff, c_in;
   logic [D_W-1:0]    q_ff, q_in;
   logic [D_W-1:0]    d_ff, d_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [KK_W-1:0]   kk_ff, kk_in;
   logic [PV_W-1:0]   pv_ff, pv_in;
   logic [TOT_W-1:0]  total_ff, total_in;
   logic [S1_W-1:0]   s1_ff, s1_in;
   logic [S2_W-1:0]   s2_ff, s2_in;
   logic [PM_W-1:0]   pm_ff, pm_in;
   logic [G_W-1:0]    g_ff, g_in;
   logic [DEN2_W-1:0] den2_ff, den2_in;
   logic [DEN_W-1:0]  den3_ff, den3_in;
   logic [DUR_W-1:0]  mac_ff, mac_in;
   logic [DUR_W-1:0]  mod_ff, mod_in;
   logic              sat_ff, sat_in;

   logic              strobe_ff, strobe_in;
   logic [VAL_W-1:0]  fair_ff, fair_in;
   logic [DUR_W-1:0]  omac_ff, omac_in;
   logic [DUR_W-1:0]  omod_ff, omod_in;
   logic [CONV_W-1:0] oconv_ff, oconv_in;
   logic [STAT_W-1:0] ostat_ff, ostat_in;

   logic [MA_W-1:0]   mul_a;
   logic [MB_W-1:0]   mul_b;
   logic [P_W-1:0]    prod;
   logic              div_go;
   logic              div_done;
   logic [NUM_W-1:0]  div_num;
   logic [DEN_W-1:0]  div_den;
   logic [NUM_W-1:0]  quo;

   logic [PPY_W-1:0]  m_acc;
   logic [NRAW_W-1:0] nraw;
   logic [YR_W-1:0]   yr;
   logic [PV_W-1:0]   cf;
   logic [D_W-1:0]    dn;
   logic [PV_W-1:0]   pv;
   logic [K_W-1:0]    kp1;
   logic              fair_sat;
   logic [VAL_W-1:0]  fair_val;
   logic              q_sat24;
   logic              q_sat32;
   logic              last;
   logic              mul_state;
   logic              adv;

   bpdc_mul #(.A_W(MA_W), .B_W(MB_W)) u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   bpdc_div #(.NUM_W(NUM_W), .D_BITS(DEN_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_go),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (quo)
   );

   // Configuration writes.
   always_comb begin
      face_in   = face_ff;
      coupon_in = coupon_ff;
      yield_in  = yield_ff;
      years_in  = years_ff;
      ppy_in    = ppy_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FACE:   face_in   = csr_write_data;
            CSR_COUPON: coupon_in = csr_write_data;
            CSR_YIELD:  yield_in  = csr_write_data[YLD_W-1:0];
            CSR_YEARS:  years_in  = csr_write_data[YRS_W-1:0];
            CSR_PPY:    ppy_in    = csr_write_data[PPY_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      m_acc    = (ppy_ff == '0) ? PPY_W'(1) : ppy_ff;
      nraw     = NRAW_W'(years_ff) * NRAW_W'(m_acc);
      yr       = YR_W'(r_ff) + YONE;
      cf       = PV_W'(c_ff) + ((k_ff == n_ff) ? PV_W'(face_ff) : '0);
      dn       = prod[2*DFRAC:DFRAC];
      pv       = prod[DFRAC+PV_W-1:DFRAC];
      kp1      = k_ff + 1'b1;
      last     = (k_ff == n_ff);
      fair_sat = |total_ff[TOT_W-1:VAL_W];
      fair_val = fair_sat ? '1 : total_ff[VAL_W-1:0];
      q_sat24  = |quo[NUM_W-1:DUR_W];
      q_sat32  = |quo[NUM_W-1:CONV_W];
      // Each state but idle and divide drives the multiplier and advances only
      // with ph_ff set, so the product of the step before has cleared the pipe.
      mul_state = (state_ff != ST_IDLE) && (state_ff != ST_DIV);
      adv       = !mul_state || ph_ff;
      ph_in     = mul_state && !ph_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      if (adv) begin
         case (state_ff)
            ST_IDLE: if (start) state_in = ST_DIV;
            ST_DIV: begin
               if (div_done) begin
                  case (dv_ff)
                     DV_Q:    state_in = (n_ff == '0) ? ST_PEND : ST_PD;
                     DV_CONV: state_in = ST_IDLE;
                     default: state_in = ST_DIV;
                  endcase
               end
            end
            ST_PD:   state_in = ST_PCF;
            ST_PCF:  state_in = ST_PK;
            ST_PK:   state_in = ST_PKK;
            ST_PKK:  state_in = last ? ST_PEND : ST_PD;
            ST_PEND: state_in = (price_ff == '0) ? ST_IDLE : ST_M1;
            ST_M1:   state_in = ST_M2;
            ST_M2:   state_in = ST_M3;
            ST_M3:   state_in = ST_M4;
            ST_M4:   state_in = ST_M5;
            ST_M5:   state_in = ST_DIV;
            default: state_in = ST_IDLE;
         endcase
      end
   end

   // Datapath and sequencer outputs.
   always_comb begin
      dv_in     = dv_ff;
      price_in  = price_ff;
      m_in      = m_ff;
      n_in      = n_ff;
      r_in      = r_ff;
      c_in      = c_ff;
      q_in      = q_ff;
      d_in      = d_ff;
      k_in      = k_ff;
      kk_in     = kk_ff;
      pv_in     = pv_ff;
      total_in  = total_ff;
      s1_in     = s1_ff;
      s2_in     = s2_ff;
      pm_in     = pm_ff;
      g_in      = g_ff;
      den2_in   = den2_ff;
      den3_in   = den3_ff;
      mac_in    = mac_ff;
      mod_in    = mod_ff;
      sat_in    = sat_ff;
      strobe_in = 1'b0;
      fair_in   = fair_ff;
      omac_in   = omac_ff;
      omod_in   = omod_ff;
      oconv_in  = oconv_ff;
      ostat_in  = ostat_ff;
      mul_a     = '0;
      mul_b     = '0;
      div_go    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               price_in = req_market_price;
               m_in     = m_acc;
               n_in     = (32'(nraw) > MAX_PERIODS) ? K_W'(MAX_PERIODS) : K_W'(nraw);
               sat_in   = 1'b0;
               dv_in    = DV_R;
               div_go   = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               case (dv_ff)
                  DV_R: begin
                     r_in   = quo[YLD_W-1:0];
                     dv_in  = DV_C;
                     div_go = 1'b1;
                  end
                  DV_C: begin
                     c_in   = quo[VAL_W-1:0];
                     dv_in  = DV_Q;
                     div_go = 1'b1;
                  end
                  DV_Q: begin
                     q_in     = quo[D_W-1:0];
                     d_in     = D_W'(1) << DFRAC;
                     k_in     = K_W'(1);
                     kk_in    = KK_W'(2);
                     total_in = (n_ff == '0) ? TOT_W'(face_ff) : '0;
                     s1_in    = '0;
                     s2_in    = '0;
                  end
                  DV_MAC: begin
                     mac_in = q_sat24 ? '1 : quo[DUR_W-1:0];
                     sat_in = sat_ff | q_sat24;
                     dv_in  = DV_MOD;
                     div_go = 1'b1;
                  end
                  DV_MOD: begin
                     mod_in = q_sat24 ? '1 : quo[DUR_W-1:0];
                     sat_in = sat_ff | q_sat24;
                     dv_in  = DV_CONV;
                     div_go = 1'b1;
                  end
                  DV_CONV: begin
                     strobe_in = 1'b1;
                     fair_in   = fair_val;
                     omac_in   = mac_ff;
                     omod_in   = mod_ff;
                     oconv_in  = q_sat32 ? '1 : quo[CONV_W-1:0];
                     ostat_in  = (sat_ff | fair_sat | q_sat32) ? STATUS_SAT : STATUS_OK;
                  end
                  default: ;
               endcase
            end
         end
         ST_PD: begin
            // The previous period's k*(k+1) weighted product lands here.
            if (k_ff != K_W'(1)) s2_in = s2_ff + S2_W'(prod);
            mul_a = MA_W'(d_ff);
            mul_b = MB_W'(q_ff);
         end
         ST_PCF: begin
            d_in  = dn;
            mul_a = MA_W'(cf);
            mul_b = MB_W'(dn);
         end
         ST_PK: begin
            pv_in    = pv;
            total_in = total_ff + TOT_W'(pv);
            mul_a    = MA_W'(pv);
            mul_b    = MB_W'(k_ff);
         end
         ST_PKK: begin
            s1_in = s1_ff + S1_W'(prod);
            mul_a = MA_W'(pv_ff);
            mul_b = MB_W'(kk_ff);
            if (!last) begin
               k_in  = kp1;
               kk_in = kk_ff + (KK_W'(kp1) << 1);
            end
         end
         ST_PEND: begin
            if (n_ff != '0) s2_in = s2_ff + S2_W'(prod);
            mul_a = MA_W'(price_ff);
            mul_b = MB_W'(m_ff);
            if (price_ff == '0) begin
               strobe_in = 1'b1;
               fair_in   = fair_val;
               omac_in   = '0;
               omod_in   = '0;
               oconv_in  = '0;
               ostat_in  = STATUS_ZERO;
            end
         end
         ST_M1: begin
            pm_in = prod[PM_W-1:0];
            mul_a = MA_W'(yr);
            mul_b = MB_W'(yr);
         end
         ST_M2: begin
            g_in  = prod[G_W+23:24];
            mul_a = MA_W'(pm_ff);
            mul_b = MB_W'(yr);
         end
         ST_M3: begin
            den2_in = prod[DEN2_W-1:0];
            mul_a   = MA_W'(pm_ff);
            mul_b   = MB_W'(m_ff);
         end
         ST_M4: begin
            mul_a = prod[PMM_W-1:0];
            mul_b = MB_W'(g_ff);
         end
         ST_M5: begin
            den3_in = prod[DEN_W-1:0];
            dv_in   = DV_MAC;
            div_go  = 1'b1;
         end
         default: ;
      endcase
      // The first cycle of a multiply step only keeps the operands steady.
      if (!adv) begin
         strobe_in = 1'b0;
         div_go    = 1'b0;
      end
   end

   // Divider operands follow the division being launched.
   always_comb begin
      case (dv_in)
         DV_R: begin
            div_num = NUM_W'(yield_ff);
            div_den = DEN_W'(m_in);
         end
         DV_C: begin
            div_num = NUM_W'(coupon_ff);
            div_den = DEN_W'(m_in);
         end
         DV_Q: begin
            div_num = NUM_W'(1) << 54;
            div_den = DEN_W'(yr);
         end
         DV_MAC: begin
            div_num = NUM_W'(s1_ff) << 16;
            div_den = DEN_W'(pm_ff);
         end
         DV_MOD: begin
            div_num = NUM_W'(s1_ff) << 40;
            div_den = DEN_W'(den2_ff);
         end
         DV_CONV: begin
            div_num = NUM_W'(s2_ff) << 40;
            div_den = den3_ff;
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         ph_ff     <= 1'b0;
         strobe_ff <= 1'b0;
         face_ff   <= '0;
         coupon_ff <= '0;
         yield_ff  <= '0;
         years_ff  <= '0;
         ppy_ff    <= PPY_W'(1);
      end else begin
         state_ff  <= state_in;
         ph_ff     <= ph_in;
         strobe_ff <= strobe_in;
         face_ff   <= face_in;
         coupon_ff <= coupon_in;
         yield_ff  <= yield_in;
         years_ff  <= years_in;
         ppy_ff    <= ppy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dv_ff    <= dv_in;
         price_ff <= price_in;
         m_ff     <= m_in;
         n_ff     <= n_in;
         r_ff     <= r_in;
         c_ff     <= c_in;
         q_ff     <= q_in;
         d_ff     <= d_in;
         k_ff     <= k_in;
         kk_ff    <= kk_in;
         pv_ff    <= pv_in;
         total_ff <= total_in;
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         pm_ff    <= pm_in;
         g_ff     <= g_in;
         den2_ff  <= den2_in;
         den3_ff  <= den3_in;
         mac_ff   <= mac_in;
         mod_ff   <= mod_in;
         sat_ff   <= sat_in;
         fair_ff  <= fair_in;
         omac_ff  <= omac_in;
         omod_ff  <= omod_in;
         oconv_ff <= oconv_in;
         ostat_ff <= ostat_in;
      end
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_strobe            = strobe_ff;
   assign rsp_fair_price        = fair_ff;
   assign rsp_macaulay_duration = omac_ff;
   assign rsp_modified_duration = omod_ff;
   assign rsp_convexity         = oconv_ff;
   assign rsp_status            = ostat_ff;

endmodule

[rtl/bpdc_check.sv]
module bpdc_check
   import bpdc_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 start,
   input logic                 busy,
   input logic [VAL_W-1:0]     req_market_price,
   input logic                 rsp_strobe,
   input logic [VAL_W-1:0]     rsp_fair_price,
   input logic [DUR_W-1:0]     rsp_macaulay_duration,
   input logic [DUR_W-1:0]     rsp_modified_duration,
   input logic [CONV_W-1:0]    rsp_convexity,
   input logic [STAT_W-1:0]    rsp_status,
   input logic                 csr_write_enable,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [VAL_W-1:0]     csr_write_data
);

   // A transfer in always starts a busy period.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   // A result only closes a busy period.
   a_strobe_end: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe outside the end of a busy period");

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe longer than one cycle");

   a_zero_price: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status == STATUS_ZERO) |->
         (rsp_macaulay_duration == '0 && rsp_modified_duration == '0 &&
          rsp_convexity == '0))
      else $error("zero price result carries nonzero risk figures");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == STATUS_OK || rsp_status == STATUS_ZERO ||
                      rsp_status == STATUS_SAT))
      else $error("undefined status code");

endmodule

bind bond_price_duration_convexity bpdc_check u_bpdc_check (.*);
